[design/box_blur_3x3_rgb_macros.svh]
// assertion macros shared by the box blur modules
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// same-cycle implication
`define BB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box blur assertion failed");

// next-cycle implication
`define BB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box blur assertion failed");

`endif

[design/bblur_pkg.sv]
// types and constants of the box blur
`default_nettype none
package bblur_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 12;
   localparam int EW        = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
   localparam int PIX_W     = 32;
   localparam int RGB_W     = 24;
   localparam int CHAN_W    = 8;
   localparam int SUM_W     = 12;
   localparam int MAX_SUM   = 9 * 255;
   localparam int RECIP     = 3641;
   localparam int RECIP_W   = 12;
   localparam int RECIP_SHIFT = 15;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(800);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(600);
   localparam logic [HEIGHT_W-1:0] ROW_LIMIT    = '1;
   localparam logic [CHAN_W-1:0]   ALPHA_FILL   = 8'hFF;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_type;

   typedef logic [COL_W-1:0] col_type;

   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } mask_type;

   typedef struct packed {
      col_type  col;
      logic     emit;
      logic     last;
      mask_type mask;
   } ctrl_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } sum_type;

endpackage
`default_nettype wire

[design/bblur_req_if.sv]
// input item channel
`default_nettype none
interface bblur_req_if import bblur_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [PIX_W-1:0] pixel_word;

   modport source (output valid, output opcode, output pixel_word, input ready);
   modport sink   (input valid, input opcode, input pixel_word, output ready);
endinterface
`default_nettype wire

[design/bblur_rsp_if.sv]
// result item channel
`default_nettype none
interface bblur_rsp_if import bblur_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blurred_word;
   logic             last_of_frame;

   modport source (output valid, output blurred_word, output last_of_frame, input ready);
   modport sink   (input valid, input blurred_word, input last_of_frame, output ready);
endinterface
`default_nettype wire

[design/box_blur_3x3_rgb.sv]
// top level of the streaming 3x3 rgb box blur
//
//   port     role     handshake       payload
//   req_bus  sink     valid/ready     opcode, pixel_word
//   rsp_bus  source   valid/ready     blurred_word, last_of_frame
//   psel...  apb      psel/penable    frame_width @0x0, frame_height @0x4
//
// one item per clock sustained while rsp_bus is ready; a result passes the window, sum and result registers in turn
// line memory reads and writes once per item at the current column, bypass covers width one
// synchronous reset clears counters, window and valid bits; line memory is not cleared
// a stalled result holds the result register, then sum stage, then window stage, then req
`default_nettype none
module box_blur_3x3_rgb import bblur_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   bblur_req_if.sink              req_bus,
   bblur_rsp_if.source            rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   reg_type             reg_sel;
   logic                csr_wr, accept, s1_ready, out_free, s2_valid, s2_last;
   logic [RGB_W-1:0]    pix;
   ctrl_type            ctrl;
   sum_type             s2_sum;

   assign pready  = 1'b1;
   assign reg_sel = reg_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  width_ff  <= pwdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[HEIGHT_W-1:0];
            default: begin
               width_ff  <= width_ff;
               height_ff <= height_ff;
            end
         endcase
      end
   end

   // no item is taken while reset is high
   assign req_bus.ready = s1_ready && !reset;
   assign accept        = req_bus.valid && s1_ready && !reset;
   assign pix           = req_bus.opcode ? '0 : req_bus.pixel_word[PIX_W-1:PIX_W-RGB_W];

   bblur_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .ctrl         (ctrl)
   );

   bblur_window u_window (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .pix      (pix),
      .ctrl     (ctrl),
      .out_free (out_free),
      .s1_ready (s1_ready),
      .s2_valid (s2_valid),
      .s2_sum   (s2_sum),
      .s2_last  (s2_last)
   );

   bblur_avg u_avg (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_sum   (s2_sum),
      .s2_last  (s2_last),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );
endmodule
`default_nettype wire

[design/bblur_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module bblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

[design/bblur_ctrl.sv]
// raster position counters and per-item control
`default_nettype none
`include "box_blur_3x3_rgb_macros.svh"
module bblur_ctrl import bblur_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [WIDTH_W-1:0]  frame_width,
   input  wire logic [HEIGHT_W-1:0] frame_height,
   output ctrl_type                 ctrl
);
   col_type             in_col_ff, in_col_in;
   col_type             out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] in_row_ff, in_row_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [EW-1:0]       w_eff, in_col_nx, out_col_nx;
   logic [HEIGHT_W-1:0] h_eff;
   logic [HEIGHT_W:0]   out_row_nx;
   logic                emit, last, bot_ok, right_ok;

   always_comb begin
      if (frame_width == '0) begin
         w_eff = EW'(1);
      end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(frame_width);
      end
      h_eff      = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
      in_col_nx  = EW'(in_col_ff) + EW'(1);
      out_col_nx = EW'(out_col_ff) + EW'(1);
      out_row_nx = {1'b0, out_row_ff} + (HEIGHT_W + 1)'(1);
      emit       = (in_row_ff >= HEIGHT_W'(2)) ||
                   ((in_row_ff == HEIGHT_W'(1)) && (in_col_ff != '0));
      bot_ok     = out_row_nx < {1'b0, h_eff};
      right_ok   = out_col_nx < w_eff;
      last       = !bot_ok && !right_ok;

      ctrl.col           = in_col_ff;
      ctrl.emit          = emit;
      ctrl.last          = last;
      ctrl.mask.top_ok   = out_row_ff != '0;
      ctrl.mask.bot_ok   = bot_ok;
      ctrl.mask.left_ok  = out_col_ff != '0;
      ctrl.mask.right_ok = right_ok;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (in_col_nx >= w_eff) begin
            in_col_in = '0;
            if (in_row_ff != ROW_LIMIT) begin
               in_row_in = in_row_ff + HEIGHT_W'(1);
            end
         end else begin
            in_col_in = in_col_nx[COL_W-1:0];
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_nx >= w_eff) begin
               out_col_in = '0;
               out_row_in = out_row_nx[HEIGHT_W-1:0];
            end else begin
               out_col_in = out_col_nx[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // end of frame returns every counter to the origin
   `BB_ASSERT_NEXT(a_last_clears, clock, reset, accept && emit && last, (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
endmodule
`default_nettype wire

[design/bblur_window.sv]
// line buffers, 3x3 window and masked channel sums
`default_nettype none
`include "box_blur_3x3_rgb_macros.svh"
module bblur_window import bblur_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [RGB_W-1:0] pix,
   input  wire ctrl_type         ctrl,
   input  wire logic             out_free,
   output logic                  s1_ready,
   output logic                  s2_valid,
   output sum_type               s2_sum,
   output logic                  s2_last
);
   logic             s1_valid_ff, s1_valid_in;
   logic [RGB_W-1:0] s1_pix_ff;
   ctrl_type         s1_ctrl_ff;
   logic             byp_ff;
   logic [RGB_W-1:0] byp_mid_ff, byp_top_ff;
   logic [RGB_W-1:0] ram_mid, ram_top, mid_eff, top_eff;
   logic [RGB_W-1:0] win_ff [3][3];
   logic [RGB_W-1:0] win_in [3][3];
   logic             s1_move, s2_free, s2_load;
   logic             s2_valid_ff, s2_valid_in;
   sum_type          s2_sum_ff, sum_in;
   logic             s2_last_ff;

   assign mid_eff  = byp_ff ? byp_mid_ff : ram_mid;
   assign top_eff  = byp_ff ? byp_top_ff : ram_top;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && (!s1_ctrl_ff.emit || s2_free);
   assign s1_ready = !s1_valid_ff || s1_move;
   assign s2_load  = s1_move && s1_ctrl_ff.emit;

   bblur_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
      .clock (clock),
      .we    (s1_move),
      .waddr (s1_ctrl_ff.col),
      .wdata (s1_pix_ff),
      .re    (accept),
      .raddr (ctrl.col),
      .rdata (ram_mid)
   );

   bblur_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_top_ram (
      .clock (clock),
      .we    (s1_move),
      .waddr (s1_ctrl_ff.col),
      .wdata (mid_eff),
      .re    (accept),
      .raddr (ctrl.col),
      .rdata (ram_top)
   );

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top_eff;
      win_in[1][2] = mid_eff;
      win_in[2][2] = s1_pix_ff;
   end

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r != 0 || s1_ctrl_ff.mask.top_ok) && (r != 2 || s1_ctrl_ff.mask.bot_ok) &&
                (c != 0 || s1_ctrl_ff.mask.left_ok) && (c != 2 || s1_ctrl_ff.mask.right_ok))
            begin
               sum_in.r = sum_in.r + SUM_W'(win_in[r][c][23:16]);
               sum_in.g = sum_in.g + SUM_W'(win_in[r][c][15:8]);
               sum_in.b = sum_in.b + SUM_W'(win_in[r][c][7:0]);
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (s2_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (accept) begin
            byp_ff <= s1_move && (ctrl.col == s1_ctrl_ff.col);
         end
         if (s1_move) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix;
         s1_ctrl_ff <= ctrl;
         byp_mid_ff <= s1_pix_ff;
         byp_top_ff <= mid_eff;
      end
      if (s2_load) begin
         s2_sum_ff  <= sum_in;
         s2_last_ff <= s1_ctrl_ff.last;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_sum   = s2_sum_ff;
   assign s2_last  = s2_last_ff;

   // an emitting item leaving the window stage always lands in the sum stage
   `BB_ASSERT_NEXT(a_emit_reaches_sum, clock, reset, s2_load, s2_valid_ff)
   // the sum stage fills only from an emitting item
   `BB_ASSERT_NEXT(a_sum_from_emit, clock, reset, !s2_valid_ff && !s2_load, !s2_valid_ff)
   // nine bytes at most per channel
   `BB_ASSERT_IMPL(a_sum_bound, clock, reset, s2_valid_ff, (s2_sum_ff.r <= SUM_W'(MAX_SUM)) && (s2_sum_ff.g <= SUM_W'(MAX_SUM)) && (s2_sum_ff.b <= SUM_W'(MAX_SUM)))
endmodule
`default_nettype wire

[design/bblur_avg.sv]
// divide by nine and result register
`default_nettype none
`include "box_blur_3x3_rgb_macros.svh"
module bblur_avg import bblur_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     s2_valid,
   input  wire sum_type  s2_sum,
   input  wire logic     s2_last,
   output logic          out_free,
   bblur_rsp_if.source   rsp_bus
);
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  word_ff, word_in;
   logic              last_ff;
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      prod_r       = PROD_W'(s2_sum.r) * PROD_W'(RECIP);
      prod_g       = PROD_W'(s2_sum.g) * PROD_W'(RECIP);
      prod_b       = PROD_W'(s2_sum.b) * PROD_W'(RECIP);
      word_in      = {prod_r[RECIP_SHIFT +: CHAN_W], prod_g[RECIP_SHIFT +: CHAN_W],
                      prod_b[RECIP_SHIFT +: CHAN_W], ALPHA_FILL};
      out_valid_in = out_free ? s2_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid) begin
         word_ff <= word_in;
         last_ff <= s2_last;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.blurred_word  = word_ff;
   assign rsp_bus.last_of_frame = last_ff;
endmodule
`default_nettype wire

[tb/tb_box_blur_3x3_rgb.sv]
// self-checking testbench for the streaming 3x3 rgb box blur with its own blur predictor
`timescale 1ns / 1ps
module tb_box_blur_3x3_rgb import bblur_pkg::*; ();

   localparam int LIMIT_NS     = 6_000_000;
   localparam int RANDOM_ITEMS = 700;
   localparam int WIDE_EXTRA   = 6;
   localparam int LONG_STALL   = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int DRAIN_GUARD  = 20000;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] word;
      logic             is_last;
   } blur_result_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bblur_req_if req_bus ();
   bblur_rsp_if rsp_bus ();

   box_blur_3x3_rgb uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;
   logic [RGB_W-1:0]    line_mem [2*MAX_WIDTH];
   logic [RGB_W-1:0]    win [9];
   int unsigned         in_col, in_row, out_col, out_row;

   blur_result_type blur_expected [$];

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned frames_done;
   int unsigned csr_accesses;
   int unsigned burst_left;
   int unsigned gap_limit;
   int unsigned stall_asks;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   function automatic void log_error(input string what);
      error_count++;
      if (error_count <= 10) $display("error at %0t: %s", $time, what);
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic bit blur_predict(input op_type op, input logic [PIX_W-1:0] word,
                                       output blur_result_type res);
      int unsigned      w, h, col, sr, sg, sb;
      logic [RGB_W-1:0] px, top, mid, v;
      bit               emit;
      w = eff_width();
      h = (cfg_height == 0) ? 1 : cfg_height;
      px = (op == OP_FLUSH) ? '0 : word[PIX_W-1:CHAN_W];
      col = in_col % MAX_WIDTH;
      top = line_mem[MAX_WIDTH + col];
      mid = line_mem[col];
      line_mem[MAX_WIDTH + col] = mid;
      line_mem[col] = px;
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         if (in_row < ROW_LIMIT) in_row++;
      end
      res = '0;
      if (!emit) return 0;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            // neighbours off the frame add nothing
            if (!((r == 0 && out_row < 1) || (r == 2 && out_row + 1 >= h) ||
                  (c == 0 && out_col < 1) || (c == 2 && out_col + 1 >= w))) begin
               v = win[r*3+c];
               sr += v[23:16];
               sg += v[15:8];
               sb += v[7:0];
            end
         end
      end
      res.word = {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA_FILL};
      res.is_last = (out_col + 1 >= w) && (out_row + 1 >= h);
      if (res.is_last) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 12'hFFF;
         end
      end
      return 1;
   endfunction

   task automatic send_item(input op_type op, input logic [PIX_W-1:0] pix);
      int unsigned     gap;
      blur_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.pixel_word <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      burst_left--;
      items_sent++;
      if (blur_predict(op, pix, res)) blur_expected.push_back(res);
   endtask

   task automatic wait_drained();
      int unsigned guard;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      guard = 0;
      while (blur_expected.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_type idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == REG_FRAME_WIDTH) cfg_width = value[WIDTH_W-1:0];
      else cfg_height = value[HEIGHT_W-1:0];
      csr_accesses++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic read_reg(input reg_type idx, input logic [DATA_W-1:0] want);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== want)
         log_error($sformatf("register %s read: expected %h got %h", idx.name(), want, prdata));
      csr_accesses++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h);
      write_reg(REG_FRAME_WIDTH, DATA_W'(w));
      write_reg(REG_FRAME_HEIGHT, DATA_W'(h));
      read_reg(REG_FRAME_WIDTH, DATA_W'(cfg_width));
      read_reg(REG_FRAME_HEIGHT, DATA_W'(cfg_height));
   endtask

   // a noisy frame mixes in black flush items and a random number of drain items
   task automatic send_frame(input int unsigned ew, input int unsigned eh, input bit noisy);
      int unsigned      n_drain;
      logic [PIX_W-1:0] pix;
      for (int unsigned i = 0; i < ew * eh; i++) begin
         case ($urandom_range(0, 9))
            0:       pix = '1;
            1:       pix = '0;
            default: pix = $urandom();
         endcase
         if (noisy && $urandom_range(0, 99) < 15) send_item(OP_FLUSH, $urandom());
         else send_item(OP_PIXEL, pix);
      end
      n_drain = noisy ? $urandom_range(0, 2 * ew + 2) : ew + 1;
      repeat (n_drain) begin
         if ($urandom_range(0, 9) == 0) send_item(OP_PIXEL, $urandom());
         else send_item(OP_FLUSH, $urandom());
      end
   endtask

   task automatic test_register_defaults();
      read_reg(REG_FRAME_WIDTH, DATA_W'(WIDTH_RESET));
      read_reg(REG_FRAME_HEIGHT, DATA_W'(HEIGHT_RESET));
   endtask

   task automatic test_directed_frames();
      logic [PIX_W-1:0] mixed [9];
      mixed = '{32'h00000000, 32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
                32'hDEADBEEF, 32'hFFFFFF00, 32'h80808080, 32'h01010101};
      gap_limit = 0;
      set_frame(3, 3);
      // all white: full sums, stray pixel in the first drain slot
      repeat (9) send_item(OP_PIXEL, '1);
      send_item(OP_PIXEL, 32'h12345678);
      repeat (3) send_item(OP_FLUSH, '0);
      // single channels, alpha only, and a black flush at the right of the middle row
      for (int i = 0; i < 9; i++) begin
         if (i == 5) send_item(OP_FLUSH, mixed[i]);
         else send_item(OP_PIXEL, mixed[i]);
      end
      repeat (4) send_item(OP_FLUSH, '1);
      wait_drained();
   endtask

   task automatic test_config_extremes();
      int unsigned widths [4];
      int unsigned heights [4];
      widths  = '{0, 1, 1, 2};
      heights = '{0, 1, 2, 3};
      gap_limit = 2;
      for (int i = 0; i < 4; i++) begin
         set_frame(widths[i], heights[i]);
         send_frame(eff_width(), (cfg_height == 0) ? 1 : cfg_height, 1'b0);
         wait_drained();
      end
      // widest setting clamps to the line length, then a shrink ends the open frame
      set_frame(2047, 1);
      repeat (MAX_WIDTH + WIDE_EXTRA) send_item(OP_PIXEL, $urandom());
      wait_drained();
      set_frame(1, 1);
      send_item(OP_FLUSH, '0);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      set_frame(16, 8);
      gap_limit = 0;
      stall_asks++;
      send_frame(16, 8, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned start, w, h, ew, eh, n_frames;
      bit          first;
      start = items_sent;
      first = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) w = $urandom_range(0, 8);
         else w = $urandom_range(9, 40);
         h = $urandom_range(0, 6);
         // keeping the old setting may continue a frame left open by noise
         if (first || $urandom_range(0, 4) != 0) set_frame(w, h);
         first = 1'b0;
         case ($urandom_range(0, 3))
            0:       gap_limit = 0;
            1:       gap_limit = 2;
            2:       gap_limit = 5;
            default: gap_limit = 12;
         endcase
         ew = eff_width();
         eh = (cfg_height == 0) ? 1 : cfg_height;
         n_frames = $urandom_range(1, 3);
         repeat (n_frames) send_frame(ew, eh, $urandom_range(0, 9) >= 8);
         wait_drained();
      end
   endtask

   // result receiver
   initial begin
      rx_mode_type mode;
      int unsigned span, hold_left, period, tick, asks_seen;
      rsp_bus.ready = 1'b0;
      mode = RX_OPEN;
      span = 0;
      hold_left = 0;
      period = 3;
      tick = 0;
      asks_seen = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (asks_seen != stall_asks) begin
            asks_seen = stall_asks;
            hold_left = LONG_STALL;
         end
         if (span == 0) begin
            span = $urandom_range(16, 160);
            mode = rx_mode_type'($urandom_range(0, 3));
            period = $urandom_range(2, 7);
         end
         span--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:     rsp_bus.ready <= 1'b1;
               RX_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 99) < 65);
               RX_PERIODIC: rsp_bus.ready <= (tick % period != 0);
               default:     rsp_bus.ready <= ($urandom_range(0, 99) < 25);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      blur_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (blur_expected.size() == 0) begin
            log_error($sformatf("unexpected result %h", rsp_bus.blurred_word));
         end else begin
            want = blur_expected.pop_front();
            if (rsp_bus.blurred_word !== want.word)
               log_error($sformatf("blurred_word: expected %h got %h",
                                   want.word, rsp_bus.blurred_word));
            if (rsp_bus.last_of_frame !== want.is_last)
               log_error($sformatf("last_of_frame: expected %b got %b",
                                   want.is_last, rsp_bus.last_of_frame));
            if (want.is_last) frames_done++;
         end
         results_checked++;
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_PIXEL;
      req_bus.pixel_word = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      frames_done = 0;
      csr_accesses = 0;
      burst_left = 0;
      gap_limit = 0;
      stall_asks = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_directed_frames();
      test_config_extremes();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      if (blur_expected.size() != 0)
         log_error($sformatf("%0d results never arrived", blur_expected.size()));
      $display("run covered %0d items, %0d results, %0d frames, %0d register accesses",
               items_sent, results_checked, frames_done, csr_accesses);
      $display("widths 0 to 2047 with clamping, heights 0 to 6, noisy frames, resizing, stall");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[box_blur_3x3_rgb.f]
+incdir+design
design/bblur_pkg.sv
design/bblur_req_if.sv
design/bblur_rsp_if.sv
design/bblur_ram.sv
design/bblur_ctrl.sv
design/bblur_window.sv
design/bblur_avg.sv
design/box_blur_3x3_rgb.sv
tb/tb_box_blur_3x3_rgb.sv
